[hw/rtl/sample_recorder_interpolated_player_defines.svh]
// assertion macros used by the checker file
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef SAMPLE_RECORDER_INTERPOLATED_PLAYER_DEFINES_SVH
`define SAMPLE_RECORDER_INTERPOLATED_PLAYER_DEFINES_SVH

// concurrent assertion, masked while reset is held
`define SRIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srip assertion failed");

// concurrent assertion that also holds through reset
`define SRIP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("srip assertion failed");

`endif

[hw/rtl/srip_pkg.sv]
// shared types and constants for the sample recorder / interpolating player
// no dependencies
package srip_pkg;

  localparam int MaxSamples = 65536;
  localparam int FracBits   = 8;
  localparam int SampleW    = 16;
  localparam int PosW       = 24;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = AddrW + 1;
  localparam int IdxW       = PosW - FracBits;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [PosW-1:0]    pos_t;
  typedef logic        [CntW-1:0]    count_t;
  typedef logic        [AddrW-1:0]   addr_t;
  typedef logic        [FracBits-1:0] frac_t;

endpackage

[hw/rtl/srip_in_if.sv]
// input stream channel: one tick of sample and control flags per transfer
// depends on srip_pkg
interface srip_in_if;
  import srip_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    record;
  logic    play;
  logic    restart;
  pos_t    read_position;

  modport source (output valid, sample_in, record, play, restart, read_position,
                  input ready);
  modport sink   (input valid, sample_in, record, play, restart, read_position,
                  output ready);
endinterface

[hw/rtl/srip_out_if.sv]
// output stream channel: one result per transfer
// depends on srip_pkg
interface srip_out_if;
  import srip_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;
  count_t  recorded_length;
  logic    store_full;

  modport source (output valid, sample_out, recorded_length, store_full,
                  input ready);
  modport sink   (input valid, sample_out, recorded_length, store_full,
                  output ready);
endinterface

[hw/rtl/sample_recorder_interpolated_player.sv]
// Sample recorder with linear-interpolating playback. One tick is taken per clock
// cycle while input ready is high. The store read is registered on the input transfer,
// and the lerp of it is loaded into the output register once the output advances. A
// stalled output holds both stages, and input ready drops once both are full. The rate
// is at most one store write and one pair of reads per tick; two mirrored copies of the
// sample store give the two read ports (the entry at the position and the one after it).
// The store needs no clearing pass after reset: only entries below the stored count, all
// written since the last record start, are ever read.
// depends on srip_pkg, srip_in_if, srip_out_if
module sample_recorder_interpolated_player (
  input  logic clk_i,
  input  logic rst_ni,
  srip_in_if.sink    in_i,
  srip_out_if.source out_o
);
  import srip_pkg::*;

  localparam int CmpW  = (IdxW > CntW) ? IdxW : CntW;
  localparam int ProdW = SampleW + FracBits + 2;

  // mirrored sample store, one read port each
  sample_t mem_a [MaxSamples];
  sample_t mem_b [MaxSamples];

  // state
  count_t count_q, count_d;
  logic   was_rec_q, was_rec_d;

  // stage 1 (memory read) and output register
  logic    s1_valid_q, s1_play_q, s1_full_q;
  frac_t   s1_frac_q;
  count_t  s1_len_q;
  sample_t rd_a_q, rd_b_q;
  logic    out_valid_q, out_full_q;
  sample_t out_sample_q;
  count_t  out_len_q;

  logic advance, accept;

  // address and write decode for the incoming tick
  logic [IdxW-1:0] idx_raw;
  logic            pos_over;
  addr_t           rd_idx, rd_nxt;
  count_t          nxt_cnt;
  frac_t           frac_sel;
  count_t          base;
  logic            room, wr_en, play_en, full;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    idx_raw  = in_i.read_position[PosW-1:FracBits];
    pos_over = CmpW'(idx_raw) >= CmpW'(count_q);
    if (pos_over || in_i.restart) begin
      rd_idx   = '0;
      frac_sel = '0;
    end else begin
      rd_idx   = addr_t'(idx_raw);
      frac_sel = in_i.read_position[FracBits-1:0];
    end
    nxt_cnt = count_t'(rd_idx) + count_t'(1);
    rd_nxt  = (nxt_cnt < count_q) ? nxt_cnt[AddrW-1:0] : '0;

    // record path: a record start restarts the store
    base  = was_rec_q ? count_q : '0;
    room  = base < count_t'(MaxSamples);
    wr_en = accept && in_i.record && room;
    full  = in_i.record && !room;

    play_en = !in_i.record && in_i.play && (count_q != '0);

    count_d   = count_q;
    was_rec_d = was_rec_q;
    if (accept) begin
      was_rec_d = in_i.record;
      if (in_i.record) begin
        count_d = room ? base + count_t'(1) : base;
      end
    end
  end

  // sample store write and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[base[AddrW-1:0]] <= in_i.sample_in;
      mem_b[base[AddrW-1:0]] <= in_i.sample_in;
    end
    if (accept) begin
      rd_a_q <= mem_a[rd_idx];
      rd_b_q <= mem_b[rd_nxt];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      was_rec_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      was_rec_q <= was_rec_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_play_q <= play_en;
      s1_full_q <= full;
      s1_frac_q <= frac_sel;
      s1_len_q  <= count_d;
    end
  end

  // interpolation a + floor((b - a) * f / 2^FracBits)
  logic signed [SampleW:0]   diff;
  logic signed [ProdW-1:0]   prod, step, sum;
  sample_t                   lerp;

  always_comb begin
    diff = (SampleW+1)'(rd_b_q) - (SampleW+1)'(rd_a_q);
    prod = ProdW'(diff) * ProdW'($signed({1'b0, s1_frac_q}));
    step = prod >>> FracBits;
    sum  = ProdW'(rd_a_q) + step;
    lerp = sum[SampleW-1:0];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_sample_q <= s1_play_q ? lerp : '0;
      out_len_q    <= s1_len_q;
      out_full_q   <= s1_full_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sample_out      = out_sample_q;
  assign out_o.recorded_length = out_len_q;
  assign out_o.store_full      = out_full_q;

endmodule

[hw/rtl/srip_checker.sv]
// port-level checks for the sample recorder / player, bound to the top level
// depends on srip_pkg and the assertion macro header
`include "sample_recorder_interpolated_player_defines.svh"

module srip_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input srip_pkg::sample_t       sample_out_i,
  input srip_pkg::count_t        recorded_length_i,
  input logic                    store_full_i
);
  import srip_pkg::*;

  // a stalled result stays offered
  `SRIP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  // a stalled result keeps its sample
  `SRIP_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(sample_out_i))
  // a dropped sample means the store is at capacity
  `SRIP_ASSERT(a_full_len,
    out_valid_i && store_full_i |-> recorded_length_i == count_t'(MaxSamples))
  // a tick that finds the store full never plays back
  `SRIP_ASSERT(a_full_silent, out_valid_i && store_full_i |-> sample_out_i == '0)
  // the length never exceeds the store
  `SRIP_ASSERT_ALWAYS(a_len_bound,
    out_valid_i |-> recorded_length_i <= count_t'(MaxSamples))

endmodule

bind sample_recorder_interpolated_player srip_checker u_srip_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .sample_out_i      (out_o.sample_out),
  .recorded_length_i (out_o.recorded_length),
  .store_full_i      (out_o.store_full)
);

[tb/sample_recorder_interpolated_player_tb.sv]
`timescale 1ns / 1ps
// testbench for the sample recorder with interpolating playback: random and directed ticks
// are scored against an in-bench model of the store and the lerp
// depends on srip_pkg, srip_in_if, srip_out_if and the sample_recorder_interpolated_player rtl
module sample_recorder_interpolated_player_tb;
  import srip_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int FracMax    = (1 << FracBits) - 1;
  localparam int LongBurst  = 200;

  typedef struct packed {
    sample_t sample_in;
    logic    record;
    logic    play;
    logic    restart;
    pos_t    read_position;
  } tick_t;

  typedef struct packed {
    sample_t sample_out;
    count_t  recorded_length;
    logic    store_full;
  } playback_t;

  logic clk;
  logic rst_n;

  srip_in_if  in_if ();
  srip_out_if out_if ();

  sample_recorder_interpolated_player dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // ticks waiting for the driver and playback values waiting for the dut
  tick_t     pending_ticks[$];
  playback_t expected_playback[$];

  // model of the recorder state
  sample_t     recorded_samples[MaxSamples];
  int unsigned recorded_count  = 0;
  logic        was_recording_q = 1'b0;

  // length tracking on the stimulus side, used to aim play positions
  int unsigned planned_len   = 0;
  logic        planned_rec   = 1'b0;
  int unsigned planned_ticks = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int          accepted_ticks = 0;
  int          mismatch_count = 0;
  int          hold_left      = 0;
  logic        hold_done      = 1'b0;
  int          cycle_count    = 0;

  tick_t     drive_tick;
  tick_t     seen_tick;
  playback_t seen_playback;
  playback_t want_playback;

  // one record or playback tick of the recorder
  function automatic playback_t record_or_play(input tick_t t);
    playback_t   r;
    int unsigned idx;
    int unsigned frac;
    int unsigned nxt;
    int          a;
    int          b;
    int          prod;
    idx          = t.read_position >> FracBits;
    frac         = t.read_position[FracBits-1:0];
    r.sample_out = '0;
    r.store_full = 1'b0;
    // out-of-range positions and restart fall back to entry zero
    if (idx >= recorded_count || t.restart) begin
      idx  = 0;
      frac = 0;
    end
    if (t.record) begin
      if (!was_recording_q) recorded_count = 0;
      was_recording_q = 1'b1;
      if (recorded_count < MaxSamples) begin
        recorded_samples[recorded_count] = t.sample_in;
        recorded_count++;
      end else begin
        r.store_full = 1'b1;
      end
    end else begin
      was_recording_q = 1'b0;
      if (t.play && recorded_count > 0) begin
        nxt  = (idx + 1 < recorded_count) ? idx + 1 : 0;
        a    = recorded_samples[idx];
        b    = recorded_samples[nxt];
        prod = (b - a) * int'(frac);
        // arithmetic shift gives the floor of the weighted step
        r.sample_out = sample_t'(a + (prod >>> FracBits));
      end
    end
    r.recorded_length = count_t'(recorded_count);
    return r;
  endfunction

  function automatic pos_t pos_at(input int unsigned idx, input int unsigned frac);
    return pos_t'((idx << FracBits) | frac);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic push_tick(input logic [SampleW-1:0] s, input logic rec, input logic ply,
                           input logic rst, input pos_t pos);
    tick_t t;
    t.sample_in     = s;
    t.record        = rec;
    t.play          = ply;
    t.restart       = rst;
    t.read_position = pos;
    pending_ticks.insert(pending_ticks.size(), t);
    if (rec) begin
      if (!planned_rec) planned_len = 0;
      if (planned_len < MaxSamples) planned_len++;
    end
    planned_rec = rec;
    planned_ticks++;
  endtask

  task automatic record_run(input int n);
    repeat (n)
      push_tick(SampleW'($urandom), 1'b1, rand_bit(), rand_bit(), pos_t'($urandom));
  endtask

  // mostly in-range playback, with restarts, wild positions and idle ticks mixed in
  task automatic play_run(input int n);
    int unsigned pick;
    int unsigned idx;
    repeat (n) begin
      pick = $urandom_range(99);
      idx  = (planned_len > 1) ? $urandom_range(planned_len - 1) : 0;
      if (pick < 8) begin
        // last entry interpolates toward entry zero
        idx = (planned_len > 0) ? planned_len - 1 : 0;
        push_tick(SampleW'($urandom), 1'b0, 1'b1, 1'b0, pos_at(idx, $urandom_range(FracMax)));
      end else if (pick < 70) begin
        push_tick(SampleW'($urandom), 1'b0, 1'b1, 1'b0, pos_at(idx, $urandom_range(FracMax)));
      end else if (pick < 78) begin
        push_tick(SampleW'($urandom), 1'b0, 1'b1, 1'b1, pos_t'($urandom));
      end else if (pick < 88) begin
        push_tick(SampleW'($urandom), 1'b0, 1'b1, rand_bit(), pos_t'($urandom));
      end else begin
        push_tick(SampleW'($urandom), 1'b0, 1'b0, rand_bit(), pos_t'($urandom));
      end
    end
  endtask

  task automatic random_part(input int n);
    int unsigned start;
    int unsigned pick;
    start = planned_ticks;
    while (planned_ticks - start < n) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_tick(SampleW'($urandom), rand_bit(), rand_bit(), rand_bit(), pos_t'($urandom));
      end else if (pick < 15) begin
        record_run(1);
        play_run($urandom_range(1, 8));
      end else begin
        record_run($urandom_range(1, 40));
        play_run($urandom_range(1, 60));
      end
    end
  endtask

  task automatic directed_part();
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(0, 0));     // play with nothing stored
    push_tick(16'h7FFF, 1'b1, 1'b0, 1'b0, pos_at(0, 0));
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(0, 8'h80)); // single entry wraps onto itself
    push_tick(16'h8000, 1'b1, 1'b0, 1'b0, pos_at(0, 0));     // new burst clears the store
    push_tick(16'h7FFF, 1'b1, 1'b0, 1'b0, pos_at(0, 0));
    push_tick(16'hFFFF, 1'b1, 1'b0, 1'b0, pos_at(0, 0));
    push_tick(16'h0001, 1'b1, 1'b0, 1'b0, pos_at(0, 0));
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(0, 8'hFF)); // largest rising step
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(1, 8'hFF)); // falling step
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(1, 8'h01)); // small fraction on the falling step
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(3, 8'h80)); // wrap to entry zero
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(4, 8'h80)); // position past the length
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, 24'hFFFFFF);
    push_tick(16'h0000, 1'b0, 1'b1, 1'b1, pos_at(2, 8'h40)); // restart
    push_tick(16'h0000, 1'b0, 1'b0, 1'b0, pos_at(2, 8'h40)); // not playing
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(2, 0));
    push_tick(16'h1234, 1'b1, 1'b1, 1'b1, pos_at(1, 8'h10)); // record wins over play
    push_tick(16'h8000, 1'b1, 1'b0, 1'b0, pos_at(0, 0));
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(0, 8'h80));
    push_tick(16'hFFFF, 1'b0, 1'b0, 1'b1, 24'hFFFFFF);
  endtask

  // record a long burst, run past its end, then play across the wrap point
  task automatic long_burst_and_play();
    push_tick(16'h0000, 1'b0, 1'b0, 1'b0, pos_at(0, 0));
    repeat (LongBurst)
      push_tick(SampleW'($urandom), 1'b1, rand_bit(), 1'b0, pos_t'($urandom));
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(LongBurst - 1, 8'h80));
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, 24'hFFFFFF);
    push_tick(16'h0000, 1'b0, 1'b1, 1'b0, pos_at(0, 8'hFF));
    play_run(100);
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_playback.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string why, input playback_t want, input playback_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected out=%0d len=%0d full=%0b, got out=%0d len=%0d full=%0b", why,
               $signed(want.sample_out), want.recorded_length, want.store_full,
               $signed(got.sample_out), got.recorded_length, got.store_full);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input driver: a new tick is offered once the previous transfer completes
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.sample_in     <= '0;
      in_if.record        <= 1'b0;
      in_if.play          <= 1'b0;
      in_if.restart       <= 1'b0;
      in_if.read_position <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_tick          = pending_ticks.pop_front();
        in_if.valid         <= 1'b1;
        in_if.sample_in     <= drive_tick.sample_in;
        in_if.record        <= drive_tick.record;
        in_if.play          <= drive_tick.play;
        in_if.restart       <= drive_tick.restart;
        in_if.read_position <= drive_tick.read_position;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off to back the dut up
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && accepted_ticks >= 300) begin
      out_if.ready <= 1'b0;
      hold_left    <= 400;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each input transfer, score each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        seen_tick.sample_in     = in_if.sample_in;
        seen_tick.record        = in_if.record;
        seen_tick.play          = in_if.play;
        seen_tick.restart       = in_if.restart;
        seen_tick.read_position = in_if.read_position;
        expected_playback.insert(expected_playback.size(), record_or_play(seen_tick));
        accepted_ticks <= accepted_ticks + 1;
      end
      if (out_if.valid && out_if.ready) begin
        seen_playback.sample_out      = out_if.sample_out;
        seen_playback.recorded_length = out_if.recorded_length;
        seen_playback.store_full      = out_if.store_full;
        if (expected_playback.size() == 0) begin
          flag_mismatch("unexpected transfer", '0, seen_playback);
        end else begin
          want_playback = expected_playback.pop_front();
          if (seen_playback.sample_out !== want_playback.sample_out ||
              seen_playback.recorded_length !== want_playback.recorded_length ||
              seen_playback.store_full !== want_playback.store_full)
            flag_mismatch("mismatch", want_playback, seen_playback);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 46;
    directed_part();
    random_part(560);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 38;
    random_part(560);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_burst_and_play();
    random_part(460);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_playback.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
